/* hdl/model_matrix_compose_assert.svh */
// Assertion macros for the model matrix composer.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef MODEL_MATRIX_COMPOSE_ASSERT_SVH
`define MODEL_MATRIX_COMPOSE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MMC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mmc assertion failed");

// Next-cycle implication, checked out of reset.
`define MMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mmc assertion failed");

`endif

/* hdl/mmc_pkg.sv */
// Shared constants, CORDIC angle table and control type of the model matrix composer.
// No dependencies.
`default_nettype none
package mmc_pkg;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int VAL_W          = 32;  // position and scale fields
  localparam int ANG_W          = 16;  // angle fields
  localparam int OUT_W          = 40;  // matrix entries
  localparam int CORDIC_STEPS   = 30;
  localparam int CW             = 34;  // CORDIC datapath width
  localparam int CORDIC_LAT     = CORDIC_STEPS + 1;
  localparam int ROT_LAT        = 2;
  localparam int APPLY_LAT      = 2;

  localparam logic signed [CW-1:0] GAIN_START = 34'sd652032874;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic signed [CW-1:0] ATAN [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
    34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
    34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
    34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
    34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
  };

  typedef struct packed {
    logic en;     // advance all stages
    logic order;  // 1: rotate*translate*scale
  } ctrl_t;
endpackage
`default_nettype wire

/* hdl/mmc_cordic.sv */
// One pipelined CORDIC lane: binary angle in, rounded sine and cosine out.
// Depends on mmc_pkg.
`default_nettype none
module mmc_cordic #(
  parameter int FRAC_BITS  = mmc_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = mmc_pkg::ANGLE_BITS_DEF,
  localparam int SW = FRAC_BITS + 3
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  mmc_pkg::ctrl_t             ctrl_i,
  input  wire                        valid_i,
  input  wire [mmc_pkg::ANG_W-1:0]   angle_i,
  output logic                       valid_o,
  output logic signed [SW-1:0]       sin_o,
  output logic signed [SW-1:0]       cos_o
);
  localparam int CW = mmc_pkg::CW;
  localparam int N  = mmc_pkg::CORDIC_STEPS;
  localparam int RS = 30 - FRAC_BITS;

  logic [31:0]          a_ext;
  logic [31:0]          a32;
  logic signed [CW-1:0] z_init;

  // Scale the angle to 32 bits per turn; whole turns drop out
  assign a_ext  = {{(32 - mmc_pkg::ANG_W){1'b0}}, angle_i};
  assign a32    = a_ext << (32 - ANGLE_BITS);
  assign z_init = {{(CW - 30){1'b0}}, a32[29:0]};

  logic signed [CW-1:0] x_q [N];
  logic signed [CW-1:0] y_q [N];
  logic signed [CW-1:0] z_q [N];
  logic [1:0]           quad_q [N];
  logic                 v_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CW-1:0] xp, yp, zp;
    logic [1:0]           qp;
    logic                 vp;
    if (i == 0) begin : g_first
      assign xp = mmc_pkg::GAIN_START;
      assign yp = '0;
      assign zp = z_init;
      assign qp = a32[31:30];
      assign vp = valid_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign qp = quad_q[i-1];
      assign vp = v_q[i-1];
    end

    // One micro-rotation per stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (ctrl_i.en) begin
        v_q[i] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        quad_q[i] <= qp;
        if (!zp[CW-1]) begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          z_q[i] <= zp - mmc_pkg::ATAN[i];
        end else begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          z_q[i] <= zp + mmc_pkg::ATAN[i];
        end
      end
    end
  end

  // Round to FRAC_BITS and unfold the quadrant
  logic signed [CW-1:0] x_rnd, y_rnd;
  logic signed [SW-1:0] cs, sn, sin_d, cos_d;

  assign x_rnd = (x_q[N-1] + (CW'(1) <<< (RS - 1))) >>> RS;
  assign y_rnd = (y_q[N-1] + (CW'(1) <<< (RS - 1))) >>> RS;
  assign cs    = x_rnd[SW-1:0];
  assign sn    = y_rnd[SW-1:0];

  always_comb begin
    unique case (quad_q[N-1])
      2'd0: begin cos_d = cs;  sin_d = sn;  end
      2'd1: begin cos_d = -sn; sin_d = cs;  end
      2'd2: begin cos_d = -cs; sin_d = -sn; end
      default: begin cos_d = sn; sin_d = -cs; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (ctrl_i.en) begin
      valid_o <= v_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end
endmodule
`default_nettype wire

/* hdl/mmc_rot.sv */
// Rotation matrix R = Rz*Rx*Ry from sines and cosines, in two product stages.
// Depends on mmc_pkg.
`default_nettype none
module mmc_rot #(
  parameter int FRAC_BITS = mmc_pkg::FRAC_BITS_DEF,
  localparam int SW = FRAC_BITS + 3
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  mmc_pkg::ctrl_t       ctrl_i,
  input  wire                  valid_i,
  input  wire signed [SW-1:0]  sx_i,
  input  wire signed [SW-1:0]  cx_i,
  input  wire signed [SW-1:0]  sy_i,
  input  wire signed [SW-1:0]  cy_i,
  input  wire signed [SW-1:0]  sz_i,
  input  wire signed [SW-1:0]  cz_i,
  output logic                 valid_o,
  output logic signed [SW-1:0] r_o [9]
);
  localparam int PW = 2 * SW;

  // Rounded fixed-point product, half rounded up
  function automatic logic signed [SW-1:0] fmul(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    p = (p + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return p[SW-1:0];
  endfunction

  logic signed [SW-1:0] sxsy_q, sxcy_q, czcy_q, czsy_q, szcy_q, szsy_q;
  logic signed [SW-1:0] szcx_q, czcx_q, cxsy_q, cxcy_q, sz_q, cz_q, sx_q;
  logic                 v1_q;

  // Stage 1: pairwise products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (ctrl_i.en) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      sxsy_q <= fmul(sx_i, sy_i);
      sxcy_q <= fmul(sx_i, cy_i);
      czcy_q <= fmul(cz_i, cy_i);
      czsy_q <= fmul(cz_i, sy_i);
      szcy_q <= fmul(sz_i, cy_i);
      szsy_q <= fmul(sz_i, sy_i);
      szcx_q <= fmul(sz_i, cx_i);
      czcx_q <= fmul(cz_i, cx_i);
      cxsy_q <= fmul(cx_i, sy_i);
      cxcy_q <= fmul(cx_i, cy_i);
      sz_q   <= sz_i;
      cz_q   <= cz_i;
      sx_q   <= sx_i;
    end
  end

  // Stage 2: triple products and sums
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      r_o[0] <= czcy_q - fmul(sz_q, sxsy_q);
      r_o[1] <= -szcx_q;
      r_o[2] <= czsy_q + fmul(sz_q, sxcy_q);
      r_o[3] <= szcy_q + fmul(cz_q, sxsy_q);
      r_o[4] <= czcx_q;
      r_o[5] <= szsy_q - fmul(cz_q, sxcy_q);
      r_o[6] <= -cxsy_q;
      r_o[7] <= sx_q;
      r_o[8] <= cxcy_q;
    end
  end
endmodule
`default_nettype wire

/* hdl/mmc_apply.sv */
// Applies scale and translation to R, rounds and saturates to the output width.
// Depends on mmc_pkg.
`default_nettype none
module mmc_apply #(
  parameter int FRAC_BITS = mmc_pkg::FRAC_BITS_DEF,
  localparam int SW = FRAC_BITS + 3
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  mmc_pkg::ctrl_t                       ctrl_i,
  input  wire                                  valid_i,
  input  wire signed [SW-1:0]                  r_i [9],
  input  wire signed [mmc_pkg::VAL_W-1:0]      pos_i [3],
  input  wire signed [mmc_pkg::VAL_W-1:0]      scl_i [3],
  output logic                                 valid_o,
  output logic signed [mmc_pkg::OUT_W-1:0]     m_o [12]
);
  localparam int VW = mmc_pkg::VAL_W;
  localparam int OW = mmc_pkg::OUT_W;
  localparam int PW = SW + VW;
  localparam int SUMW = PW + 3;
  localparam logic signed [SUMW-1:0] SMAX = {{(SUMW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
  localparam logic signed [SUMW-1:0] SMIN = ~SMAX;

  function automatic logic signed [OW-1:0] sat_rnd(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] t;
    t = (v + (SUMW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > SMAX) t = SMAX;
    if (t < SMIN) t = SMIN;
    return t[OW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] sat_pos(input logic signed [VW-1:0] v);
    return OW'(v);
  endfunction

  logic signed [PW-1:0] ps_q [9];
  logic signed [PW-1:0] pp_q [9];
  logic signed [VW-1:0] pos_q [3];
  logic                 v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (ctrl_i.en) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  // Stage 1: products with scale and position
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      for (int k = 0; k < 9; k++) begin
        ps_q[k] <= PW'(r_i[k]) * PW'(scl_i[k % 3]);
        pp_q[k] <= PW'(r_i[k]) * PW'(pos_i[k % 3]);
      end
      for (int k = 0; k < 3; k++) pos_q[k] <= pos_i[k];
    end
  end

  // Stage 2: round, sum translation (order 1) or pass position (order 0), saturate into the output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) m_o[i*4+j] <= sat_rnd(SUMW'(ps_q[i*3+j]));
        if (ctrl_i.order)
          m_o[i*4+3] <= sat_rnd(SUMW'(pp_q[i*3]) + SUMW'(pp_q[i*3+1]) + SUMW'(pp_q[i*3+2]));
        else
          m_o[i*4+3] <= sat_pos(pos_q[i]);
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/model_matrix_compose.sv */
// Top level of the model matrix composer: stream ports, config register, pipeline.
// Depends on mmc_pkg, mmc_cordic, mmc_rot, mmc_apply and model_matrix_compose_assert.svh.
//
//  channel  direction  handshake                     payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   pose, 240 bits
//  m_axis   out        m_axis_tvalid/m_axis_tready   matrix rows 0..2, 480 bits
//  cfg      in         cfg_valid_i/cfg_ready_o       compose_order, 1 bit
//
// One pose enters per cycle while the output is not stalled; the pipeline has 30 CORDIC
// micro-rotation stages, one rounding stage, two rotation product stages, two apply stages.
// A stall at the output freezes every stage at once; nothing is lost or repeated.
// Reset clears all valid bits and sets compose_order to 0.
`default_nettype none
module model_matrix_compose #(
  parameter int FRAC_BITS  = mmc_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = mmc_pkg::ANGLE_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, angle_about_x, angle_about_y, angle_about_z,
  // scale_x, scale_y, scale_z
  input  wire  [239:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23
  output logic [479:0] m_axis_tdata,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [0:0]   cfg_data_i
);
  localparam int SW = FRAC_BITS + 3;
  localparam int VW = mmc_pkg::VAL_W;
  localparam int OW = mmc_pkg::OUT_W;
  localparam int D  = mmc_pkg::CORDIC_LAT + mmc_pkg::ROT_LAT;

  mmc_pkg::ctrl_t ctrl;
  logic           order_q;
  logic           en;

  // Config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else if (cfg_valid_i) begin
      order_q <= cfg_data_i[0];
    end
  end

  // Advance whenever the output register is free or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign ctrl.en       = en;
  assign ctrl.order    = order_q;

  // Sine/cosine lanes
  logic                 lane_v [3];
  logic signed [SW-1:0] sn [3];
  logic signed [SW-1:0] cs [3];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    mmc_cordic #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .valid_i (s_axis_tvalid),
      .angle_i (s_axis_tdata[96 + a*16 +: 16]),
      .valid_o (lane_v[a]),
      .sin_o   (sn[a]),
      .cos_o   (cs[a])
    );
  end

  logic                 rot_v;
  logic signed [SW-1:0] r [9];

  mmc_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .valid_i (lane_v[0]),
    .sx_i    (sn[0]),
    .cx_i    (cs[0]),
    .sy_i    (sn[1]),
    .cy_i    (cs[1]),
    .sz_i    (sn[2]),
    .cz_i    (cs[2]),
    .valid_o (rot_v),
    .r_o     (r)
  );

  // Delay position and scale alongside the CORDIC and rotation stages
  logic [6*VW-1:0] side_q [D];
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= {s_axis_tdata[239:144], s_axis_tdata[95:0]};
      for (int k = 1; k < D; k++) side_q[k] <= side_q[k-1];
    end
  end

  logic signed [VW-1:0] pos [3];
  logic signed [VW-1:0] scl [3];
  for (genvar k = 0; k < 3; k++) begin : g_side
    assign pos[k] = side_q[D-1][k*VW +: VW];
    assign scl[k] = side_q[D-1][(3 + k)*VW +: VW];
  end

  logic signed [OW-1:0] m [12];

  mmc_apply #(.FRAC_BITS(FRAC_BITS)) u_apply (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .valid_i (rot_v),
    .r_i     (r),
    .pos_i   (pos),
    .scl_i   (scl),
    .valid_o (m_axis_tvalid),
    .m_o     (m)
  );

  for (genvar k = 0; k < 12; k++) begin : g_out
    assign m_axis_tdata[k*OW +: OW] = m[k];
  end

  `include "model_matrix_compose_assert.svh"

  `MMC_ASSERT_IMPL(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `MMC_ASSERT_IMPL(a_lanes_lockstep, 1'b1, (lane_v[0] == lane_v[1]) && (lane_v[1] == lane_v[2]))
  `MMC_ASSERT_IMPL(a_out_rises_on_advance, $rose(m_axis_tvalid), $past(en))
endmodule
`default_nettype wire

/* tb/mmc_checker.sv */
// Checker for the model matrix composer: watches the pose, matrix and config channels,
// predicts each matrix from the pose and compares it. Depends on mmc_pkg.
module mmc_checker (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire  [239:0] s_axis_tdata,
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  input  wire  [479:0] m_axis_tdata,
  input  wire          cfg_valid_i,
  input  wire          cfg_ready_o,
  input  wire  [0:0]   cfg_data_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           matrices_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = mmc_pkg::FRAC_BITS_DEF;
  localparam int ABITS = mmc_pkg::ANGLE_BITS_DEF;
  localparam longint OUT_HI = 64'sd549755813887;
  localparam longint OUT_LO = -64'sd549755813888;

  logic [479:0] matrix_q[$];
  logic         order_q;

  function automatic longint rshift_round(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rshift_round(a * b, FRAC);
  endfunction

  function automatic logic [39:0] clamp40(longint v);
    longint c;
    c = v > OUT_HI ? OUT_HI : (v < OUT_LO ? OUT_LO : v);
    return c[39:0];
  endfunction

  // CORDIC sine and cosine with quadrant folding
  function automatic void sin_cos(logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a32;
    longint x, y, z, dx, dy, cs, sn;
    a32 = {ang[ABITS-1:0], {(32-ABITS){1'b0}}};
    x = 652032874;
    y = 0;
    z = longint'(a32[29:0]);
    for (int i = 0; i < mmc_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(mmc_pkg::ATAN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(mmc_pkg::ATAN[i]);
      end
    end
    cs = rshift_round(x, 30 - FRAC);
    sn = rshift_round(y, 30 - FRAC);
    case (a32[31:30])
      2'd0: begin c = cs;  s = sn;  end
      2'd1: begin c = -sn; s = cs;  end
      2'd2: begin c = -cs; s = -sn; end
      default: begin c = sn; s = -cs; end
    endcase
  endfunction

  function automatic logic [479:0] compose_matrix(logic [239:0] pose, logic ord);
    longint pos[3], scl[3], r[3][3];
    longint sx, cx, sy, cy, sz, cz, t;
    logic [479:0] m;
    for (int i = 0; i < 3; i++) begin
      pos[i] = longint'($signed(pose[32*i +: 32]));
      scl[i] = longint'($signed(pose[144 + 32*i +: 32]));
    end
    sin_cos(pose[96 +: 16], sx, cx);
    sin_cos(pose[112 +: 16], sy, cy);
    sin_cos(pose[128 +: 16], sz, cz);
    r[0][0] = qmul(cz, cy) - qmul(sz, qmul(sx, sy));
    r[0][1] = -qmul(sz, cx);
    r[0][2] = qmul(cz, sy) + qmul(sz, qmul(sx, cy));
    r[1][0] = qmul(sz, cy) + qmul(cz, qmul(sx, sy));
    r[1][1] = qmul(cz, cx);
    r[1][2] = qmul(sz, sy) - qmul(cz, qmul(sx, cy));
    r[2][0] = -qmul(cx, sy);
    r[2][1] = sx;
    r[2][2] = qmul(cx, cy);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) m[40*(4*i+j) +: 40] = clamp40(qmul(r[i][j], scl[j]));
      if (ord)
        t = rshift_round(r[i][0]*pos[0] + r[i][1]*pos[1] + r[i][2]*pos[2], FRAC);
      else
        t = pos[i];
      m[40*(4*i+3) +: 40] = clamp40(t);
    end
    return m;
  endfunction

  assign pending_o = matrix_q.size();

  // Track the register, predict on each pose beat, compare on each matrix beat
  always @(posedge clk_i or negedge rst_ni) begin
    logic [479:0] want;
    int           bad;
    if (!rst_ni) begin
      order_q <= 1'b0;
      fail_count_o <= 0;
      matrices_seen_o <= 0;
      matrix_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) order_q <= cfg_data_i[0];
      if (s_axis_tvalid && s_axis_tready)
        matrix_q.push_back(compose_matrix(s_axis_tdata, order_q));
      if (m_axis_tvalid && m_axis_tready) begin
        matrices_seen_o <= matrices_seen_o + 1;
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected matrix beat, actual %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = matrix_q.pop_front();
          bad = 0;
          for (int k = 0; k < 12; k++)
            if (want[40*k +: 40] !== m_axis_tdata[40*k +: 40]) begin
              $display("%0t: entry m%0d%0d expected %h actual %h", $time, k / 4, k % 4,
                       want[40*k +: 40], m_axis_tdata[40*k +: 40]);
              bad++;
            end
          if (bad != 0) fail_count_o <= fail_count_o + bad;
        end
      end
    end
  end
endmodule

/* tb/testbench.sv */
// Top of the model matrix composer testbench: clock, reset, pose and config stimulus,
// output stalls and verdict. Depends on mmc_pkg, model_matrix_compose and mmc_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = mmc_pkg::CORDIC_LAT + mmc_pkg::ROT_LAT + mmc_pkg::APPLY_LAT;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [479:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [0:0]   cfg_data_i = '0;
  int           fail_count, pending, matrices_seen;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           hold_off = 0;
  int           poses_sent = 0;

  always #5 clk_i = ~clk_i;

  model_matrix_compose u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  mmc_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .matrices_seen_o(matrices_seen)
  );

  // Stall the output at random; a long hold-off overrides
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
      3: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [239:0] rand_pose();
    logic [239:0] p;
    for (int i = 0; i < 3; i++) begin
      p[32*i +: 32] = rand_value();
      p[96 + 16*i +: 16] = $urandom_range(3) == 0 ? 16'(16384 * $urandom_range(3))
                                                  : 16'($urandom);
      p[144 + 32*i +: 32] = rand_value();
    end
    return p;
  endfunction

  // Idle a random number of cycles, then offer one pose beat and hold it until accepted
  task automatic send_pose(logic [239:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    poses_sent++;
  endtask

  // Stop offering poses and wait until every expected matrix has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // Write compose_order while the pipeline is empty
  task automatic write_order(logic ord);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= ord;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed_poses();
    logic [239:0] p;
    logic [31:0]  ext[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    logic [15:0]  ang[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2000};
    for (int k = 0; k < 12; k++) begin
      for (int i = 0; i < 3; i++) begin
        p[32*i +: 32] = ext[(k + i) % 4];
        p[96 + 16*i +: 16] = ang[(k + 2*i) % 6];
        p[144 + 32*i +: 32] = ext[(k + i + 1) % 4];
      end
      send_pose(p);
    end
  endtask

  initial begin
    int pct[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{37, 37}};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed poses under both compose orders
    directed_poses();
    write_order(1'b1);
    directed_poses();
    // Random phases through every idling mix, alternating the order
    for (int ph = 0; ph < 8; ph++) begin
      write_order(ph[0]);
      send_idle_pct = pct[ph % 4][0];
      stall_pct = pct[ph % 4][1];
      if (ph == 1) hold_off <= 200;
      for (int n = 0; n < 135; n++) send_pose(rand_pose());
    end
    drain();
    $display("testbench: %0d poses sent, %0d matrices checked over both orders",
             poses_sent, matrices_seen);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
